### design/bitmap_page_frame_allocator_defines.svh
// Assertion macros shared by the page frame allocator.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### design/bpfa_pkg.sv
// Types and constants of the bitmap page frame allocator.
package bpfa_pkg;

  // Fixed widths of the register and item fields.
  localparam int FRAME_W   = 20;
  localparam int PAGES_W   = 16;
  localparam int ADDR_W    = 32;
  localparam int OFFSET_W  = 12;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int MAX_REGIONS = 3;
  // Width of index and prefix arithmetic: three 16-bit counts plus a 20-bit frame.
  localparam int CALC_W    = 21;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_OOM    = 2'd1,
    STATUS_DOUBLE = 2'd2,
    STATUS_BAD    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION0_BASE  = 3'd0,
    CFG_REGION0_PAGES = 3'd1,
    CFG_REGION1_BASE  = 3'd2,
    CFG_REGION1_PAGES = 3'd3,
    CFG_REGION2_BASE  = 3'd4,
    CFG_REGION2_PAGES = 3'd5,
    CFG_REGIONS_USED  = 3'd6,
    CFG_RESERVED      = 3'd7
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_CLAIM,
    ST_FREE_MAP,
    ST_FREE_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] base;
    logic [PAGES_W-1:0] pages;
  } region_t;

  typedef struct packed {
    logic              hit;
    logic [CALC_W-1:0] index;
  } free_map_t;

endpackage

### design/bpfa_bitmap_ram.sv
// Single-port-write, registered-read memory holding the free bitmap.
module bpfa_bitmap_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [bpfa_pkg::WORD_W-1:0]  wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [bpfa_pkg::WORD_W-1:0]  rdata
);

  logic [bpfa_pkg::WORD_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/bpfa_region_map.sv
// Translation between page indices and frame numbers across the regions.
module bpfa_region_map #(
  parameter int NUM_REGIONS = 3
) (
  input  bpfa_pkg::region_t [bpfa_pkg::MAX_REGIONS-1:0] regions,
  input  logic [1:0]                                    regions_in_use,
  input  logic [bpfa_pkg::CALC_W-1:0]                   alloc_index,
  input  logic [bpfa_pkg::FRAME_W-1:0]                  free_frame,
  output logic [bpfa_pkg::CALC_W-1:0]                   page_sum,
  output logic [bpfa_pkg::FRAME_W-1:0]                  alloc_frame,
  output bpfa_pkg::free_map_t                           free_map
);

  localparam logic [1:0] REGION_CAP = 2'(NUM_REGIONS);

  logic [1:0] active;

  // Only the leading regions up to the built-in count are valid.
  assign active = (regions_in_use > REGION_CAP) ? REGION_CAP : regions_in_use;

  // Walk the regions in order; the lowest numbered match wins on both paths.
  always_comb begin
    logic [bpfa_pkg::CALC_W-1:0] prefix;
    logic [bpfa_pkg::CALC_W-1:0] pages_ext;
    logic [bpfa_pkg::CALC_W-1:0] base_ext;
    logic [bpfa_pkg::FRAME_W-1:0] offset;
    logic                        alloc_found;
    prefix      = '0;
    pages_ext   = '0;
    base_ext    = '0;
    offset      = '0;
    alloc_found = 1'b0;
    alloc_frame = '0;
    free_map    = '0;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      if (2'(r) < active) begin
        pages_ext = bpfa_pkg::CALC_W'(regions[r].pages);
        base_ext  = bpfa_pkg::CALC_W'(regions[r].base);
        // Index to frame: earlier regions have been passed over already.
        if (!alloc_found && (alloc_index < prefix + pages_ext)) begin
          alloc_found = 1'b1;
          alloc_frame = bpfa_pkg::FRAME_W'(base_ext + alloc_index - prefix);
        end
        // Frame to index.
        offset = free_frame - regions[r].base;
        if (!free_map.hit && (free_frame >= regions[r].base) &&
            (bpfa_pkg::CALC_W'(offset) < pages_ext)) begin
          free_map.hit   = 1'b1;
          free_map.index = prefix + bpfa_pkg::CALC_W'(offset);
        end
        prefix = prefix + pages_ext;
      end
    end
    page_sum = prefix;
  end

endmodule

### design/bitmap_page_frame_allocator.sv
// Top level of the first-fit bitmap page frame allocator; one item is worked on at a time.
// Init writes one word per cycle; allocate reads one word per cycle until a word with a free
// page turns up or the words in use run out (out of memory), then claims the page; free maps the
// address, reads its word and sets the page bit (a bad address skips both); an idle action or
// an allocate with no pages goes straight to the result, and a full, stalled result register
// holds it back. Reset clears control and configuration (reserved count to one), not the bitmap.
module bitmap_page_frame_allocator #(
  parameter int MAX_PAGES   = 32768,
  parameter int NUM_REGIONS = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [bpfa_pkg::ADDR_W-1:0]       in_free_address,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bpfa_pkg::FRAME_W-1:0]      out_page_frame,
  output logic [1:0]                        out_status,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

`include "bitmap_page_frame_allocator_defines.svh"

  localparam int WORDS = (MAX_PAGES + 31) / 32;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TW    = $clog2(MAX_PAGES + 1);
  localparam int CW    = bpfa_pkg::CALC_W;
  localparam int FW    = bpfa_pkg::FRAME_W;
  localparam int DW    = bpfa_pkg::WORD_W;
  localparam int BW    = bpfa_pkg::BIT_W;
  localparam int OW    = bpfa_pkg::OFFSET_W;
  localparam int PW    = bpfa_pkg::PAGES_W;

  // Configuration and bitmap bookkeeping.
  bpfa_pkg::region_t [bpfa_pkg::MAX_REGIONS-1:0] regions_r;
  logic [1:0]            regions_in_use_r;
  logic [PW-1:0]         reserved_r;
  logic [TW-1:0]         total_pages_r;

  // Control.
  bpfa_pkg::state_t      state_r, state_nxt;
  logic                  out_valid_r;
  logic                  chk_vld_r;

  // Working registers.
  logic [bpfa_pkg::ADDR_W-1:0] addr_r;
  logic [WW-1:0]         init_w_r;
  logic [WW:0]           rd_w_r;
  logic [WW-1:0]         chk_w_r;
  logic [WW-1:0]         claim_w_r;
  logic [BW-1:0]         claim_b_r;
  logic [DW-1:0]         claim_word_r;
  logic [WW-1:0]         free_w_r;
  logic [BW-1:0]         free_b_r;
  logic [FW-1:0]         res_frame_r;
  bpfa_pkg::status_t     res_status_r;
  logic [FW-1:0]         out_frame_r;
  bpfa_pkg::status_t     out_status_r;

  // Memory port signals.
  logic                  mem_we;
  logic [WW-1:0]         mem_waddr;
  logic [DW-1:0]         mem_wdata;
  logic                  mem_re;
  logic [WW-1:0]         mem_raddr;
  logic [DW-1:0]         mem_rdata;

  // Region mapping.
  logic [CW-1:0]         page_sum;
  logic [FW-1:0]         alloc_frame;
  bpfa_pkg::free_map_t   free_map;

  logic                  in_xfer;
  logic                  out_room;
  logic [TW-1:0]         total_nxt;
  logic [WW:0]           words_used;
  logic                  scan_issue;
  logic                  scan_hit;
  logic                  scan_last;
  logic [DW-1:0]         low_onehot;
  logic [BW-1:0]         low_bit;
  logic [DW-1:0]         scan_cleared;
  logic                  free_ok;
  logic [DW-1:0]         init_mask;
  bpfa_pkg::action_t     in_act;

  assign in_act    = bpfa_pkg::action_t'(in_action);
  assign in_xfer   = in_valid && !in_stall;
  assign out_room  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_page_frame = out_frame_r;
  assign out_status     = out_status_r;

  bpfa_bitmap_ram #(
    .DEPTH (WORDS),
    .AW    (WW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bpfa_region_map #(
    .NUM_REGIONS (NUM_REGIONS)
  ) u_map (
    .regions        (regions_r),
    .regions_in_use (regions_in_use_r),
    .alloc_index    (CW'({claim_w_r, claim_b_r})),
    .free_frame     (addr_r[bpfa_pkg::ADDR_W-1:OW]),
    .page_sum       (page_sum),
    .alloc_frame    (alloc_frame),
    .free_map       (free_map)
  );

  // Page total saturates at the bitmap size.
  assign total_nxt  = (page_sum > CW'(MAX_PAGES)) ? TW'(MAX_PAGES) : TW'(page_sum);
  assign words_used = (WW + 1)'((32'(total_pages_r) + 32'd31) >> 5);

  // Scan pipeline: a read is issued per cycle while the check looks at the last word read.
  assign scan_issue   = (state_r == bpfa_pkg::ST_SCAN) && (rd_w_r < words_used);
  assign scan_hit     = chk_vld_r && (mem_rdata != '0);
  assign scan_last    = chk_vld_r && (((WW + 1)'(chk_w_r) + (WW + 1)'(1)) == words_used);
  assign low_onehot   = mem_rdata & (~mem_rdata + DW'(1));
  assign scan_cleared = mem_rdata & (mem_rdata - DW'(1));

  // Position of the lowest free page in the word just read.
  always_comb begin
    low_bit = '0;
    for (int b = 0; b < DW; b++) begin
      if (low_onehot[b]) begin
        low_bit = low_bit | BW'(b);
      end
    end
  end

  // A free request must be page aligned and map below the page total.
  assign free_ok = (addr_r[OW-1:0] == '0) && free_map.hit &&
                   (free_map.index < CW'(total_pages_r));

  // Init word: pages from the reserved count up to the total are free.
  always_comb begin
    logic [31:0] w_ext;
    logic [31:0] rsv_w;
    logic [31:0] tot_w;
    logic [5:0]  lo;
    logic [5:0]  hi;
    w_ext = 32'(init_w_r);
    rsv_w = 32'(reserved_r) >> 5;
    tot_w = 32'(total_pages_r) >> 5;
    if (w_ext < rsv_w) begin
      lo = 6'd32;
    end else if (w_ext == rsv_w) begin
      lo = 6'(reserved_r[BW-1:0]);
    end else begin
      lo = 6'd0;
    end
    if (w_ext < tot_w) begin
      hi = 6'd32;
    end else if (w_ext == tot_w) begin
      hi = 6'(total_pages_r[BW-1:0]);
    end else begin
      hi = 6'd0;
    end
    for (int b = 0; b < DW; b++) begin
      init_mask[b] = (6'(b) >= lo) && (6'(b) < hi);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpfa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_act)
            bpfa_pkg::ACT_INIT:  state_nxt = bpfa_pkg::ST_INIT;
            bpfa_pkg::ACT_ALLOC: state_nxt = (total_pages_r == '0) ? bpfa_pkg::ST_DONE
                                                                   : bpfa_pkg::ST_SCAN;
            bpfa_pkg::ACT_FREE:  state_nxt = bpfa_pkg::ST_FREE_MAP;
            bpfa_pkg::ACT_NOP:   state_nxt = bpfa_pkg::ST_DONE;
          endcase
        end
      end
      bpfa_pkg::ST_INIT: begin
        if (init_w_r == WW'(WORDS - 1)) begin
          state_nxt = bpfa_pkg::ST_DONE;
        end
      end
      bpfa_pkg::ST_SCAN: begin
        priority if (scan_hit) begin
          state_nxt = bpfa_pkg::ST_CLAIM;
        end else if (scan_last) begin
          state_nxt = bpfa_pkg::ST_DONE;
        end
      end
      bpfa_pkg::ST_CLAIM:    state_nxt = bpfa_pkg::ST_DONE;
      bpfa_pkg::ST_FREE_MAP: state_nxt = free_ok ? bpfa_pkg::ST_FREE_CHK : bpfa_pkg::ST_DONE;
      bpfa_pkg::ST_FREE_CHK: state_nxt = bpfa_pkg::ST_DONE;
      bpfa_pkg::ST_DONE: begin
        if (out_room) begin
          state_nxt = bpfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bpfa_pkg::ST_IDLE;
    endcase
  end

  // State outputs: input handshake and memory port control.
  always_comb begin
    in_stall  = (state_r != bpfa_pkg::ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = init_w_r;
    mem_wdata = init_mask;
    mem_re    = 1'b0;
    mem_raddr = rd_w_r[WW-1:0];
    unique case (state_r)
      bpfa_pkg::ST_INIT: begin
        mem_we = 1'b1;
      end
      bpfa_pkg::ST_SCAN: begin
        mem_re = scan_issue;
      end
      bpfa_pkg::ST_CLAIM: begin
        mem_we    = 1'b1;
        mem_waddr = claim_w_r;
        mem_wdata = claim_word_r;
      end
      bpfa_pkg::ST_FREE_MAP: begin
        mem_re    = free_ok;
        mem_raddr = WW'(free_map.index >> 5);
      end
      bpfa_pkg::ST_FREE_CHK: begin
        mem_we    = !mem_rdata[free_b_r];
        mem_waddr = free_w_r;
        mem_wdata = mem_rdata | (DW'(1) << free_b_r);
      end
      default: begin
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= bpfa_pkg::ST_IDLE;
      out_valid_r      <= 1'b0;
      chk_vld_r        <= 1'b0;
      regions_r        <= '0;
      regions_in_use_r <= '0;
      reserved_r       <= PW'(1);
      total_pages_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= scan_issue;
      if ((state_r == bpfa_pkg::ST_DONE) && out_room) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer && (in_act == bpfa_pkg::ACT_INIT)) begin
        total_pages_r <= total_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (bpfa_pkg::cfg_index_t'(cfg_index))
          bpfa_pkg::CFG_REGION0_BASE:  regions_r[0].base  <= cfg_data[FW-1:0];
          bpfa_pkg::CFG_REGION0_PAGES: regions_r[0].pages <= cfg_data[PW-1:0];
          bpfa_pkg::CFG_REGION1_BASE:  regions_r[1].base  <= cfg_data[FW-1:0];
          bpfa_pkg::CFG_REGION1_PAGES: regions_r[1].pages <= cfg_data[PW-1:0];
          bpfa_pkg::CFG_REGION2_BASE:  regions_r[2].base  <= cfg_data[FW-1:0];
          bpfa_pkg::CFG_REGION2_PAGES: regions_r[2].pages <= cfg_data[PW-1:0];
          bpfa_pkg::CFG_REGIONS_USED:  regions_in_use_r   <= cfg_data[1:0];
          bpfa_pkg::CFG_RESERVED:      reserved_r         <= cfg_data[PW-1:0];
        endcase
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_w_r  <= rd_w_r + (WW + 1)'(1);
      chk_w_r <= rd_w_r[WW-1:0];
    end
    unique case (state_r)
      bpfa_pkg::ST_IDLE: begin
        addr_r       <= in_free_address;
        init_w_r     <= '0;
        rd_w_r       <= '0;
        res_frame_r  <= '0;
        res_status_r <= (in_act == bpfa_pkg::ACT_ALLOC) ? bpfa_pkg::STATUS_OOM
                                                        : bpfa_pkg::STATUS_OK;
      end
      bpfa_pkg::ST_INIT: begin
        init_w_r <= init_w_r + WW'(1);
      end
      bpfa_pkg::ST_SCAN: begin
        if (scan_hit) begin
          claim_w_r    <= chk_w_r;
          claim_b_r    <= low_bit;
          claim_word_r <= scan_cleared;
        end
      end
      bpfa_pkg::ST_CLAIM: begin
        res_frame_r  <= alloc_frame;
        res_status_r <= bpfa_pkg::STATUS_OK;
      end
      bpfa_pkg::ST_FREE_MAP: begin
        free_w_r     <= WW'(free_map.index >> 5);
        free_b_r     <= free_map.index[BW-1:0];
        res_status_r <= free_ok ? bpfa_pkg::STATUS_OK : bpfa_pkg::STATUS_BAD;
      end
      bpfa_pkg::ST_FREE_CHK: begin
        res_status_r <= mem_rdata[free_b_r] ? bpfa_pkg::STATUS_DOUBLE : bpfa_pkg::STATUS_OK;
      end
      bpfa_pkg::ST_DONE: begin
        if (out_room) begin
          out_frame_r  <= res_frame_r;
          out_status_r <= res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  // An accepted transfer always starts work away from idle.
  `BPFA_ASSERT_NEXT(a_accept_leaves_idle, in_xfer, state_r != bpfa_pkg::ST_IDLE)
  // The bitmap is never written while no item is in progress.
  `BPFA_ASSERT_NOW(a_no_write_idle, state_r == bpfa_pkg::ST_IDLE, !mem_we)
  // A new result only appears after the done state.
  `BPFA_ASSERT_NOW(a_result_from_done, out_valid_r && !$past(out_valid_r),
                   $past(state_r) == bpfa_pkg::ST_DONE)

endmodule

### test/tb_bitmap_page_frame_allocator.sv
// Self-checking testbench for the first-fit bitmap page frame allocator.
`timescale 1ns / 100ps

module tb_bitmap_page_frame_allocator;

  localparam int PAGE_LIMIT   = 32768;
  localparam int REGION_SLOTS = 3;

  typedef struct {
    bpfa_pkg::action_t                 action;
    logic [bpfa_pkg::ADDR_W-1:0]       addr;
  } page_req_t;

  typedef struct {
    logic [bpfa_pkg::FRAME_W-1:0]      frame;
    bpfa_pkg::status_t                 status;
  } page_resp_t;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_mode_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [1:0]                          in_action = bpfa_pkg::ACT_NOP;
  logic [bpfa_pkg::ADDR_W-1:0]         in_free_address = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [bpfa_pkg::FRAME_W-1:0]        out_page_frame;
  logic [1:0]                          out_status;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [bpfa_pkg::CFG_IDX_W-1:0]      cfg_index = bpfa_pkg::CFG_REGION0_BASE;
  logic [bpfa_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  bitmap_page_frame_allocator #(
    .MAX_PAGES   (PAGE_LIMIT),
    .NUM_REGIONS (REGION_SLOTS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_free_address (in_free_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_page_frame  (out_page_frame),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the layout registers and of the free-page bitmap.
  logic [bpfa_pkg::FRAME_W-1:0] lay_base [REGION_SLOTS] = '{default: '0};
  logic [bpfa_pkg::PAGES_W-1:0] lay_pages [REGION_SLOTS] = '{default: '0};
  logic [1:0]                   lay_used = '0;
  logic [bpfa_pkg::PAGES_W-1:0] lay_reserved = 16'd1;
  bit                           page_free [PAGE_LIMIT];
  int unsigned                  page_total = 0;

  page_req_t  request_q [$];
  page_resp_t outcome_q [$];
  int         reqs_issued = 0;
  int         reqs_taken = 0;
  int         error_count = 0;

  // Driver and monitor bookkeeping.
  page_req_t   cur_req;
  logic        launch_valid;
  int          gap_left = 0;
  int          burst_left = 0;
  page_resp_t  want_now;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_span = 0;
  int          stall_span = 0;
  logic        next_stall;

  task automatic flag_error(string what);
    error_count++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // Number of regions that take part in the page numbering.
  function automatic int unsigned live_regions();
    int unsigned n = lay_used;
    if (n > REGION_SLOTS) n = REGION_SLOTS;
    return n;
  endfunction

  // Init: leading reserved pages used, the rest of the saturated total free.
  function automatic void rebuild_bitmap();
    int unsigned sum = 0;
    int unsigned n = live_regions();
    for (int r = 0; r < n; r++) sum += lay_pages[r];
    if (sum > PAGE_LIMIT) sum = PAGE_LIMIT;
    page_total = sum;
    for (int i = 0; i < PAGE_LIMIT; i++) page_free[i] = (i >= lay_reserved) && (i < sum);
  endfunction

  // Page index to frame, walking the regions with the current registers.
  function automatic logic [bpfa_pkg::FRAME_W-1:0] frame_of_page(int unsigned idx);
    int unsigned n = live_regions();
    logic [31:0] sum;
    for (int r = 0; r < n; r++) begin
      if (idx < lay_pages[r]) begin
        sum = lay_base[r] + idx;
        return sum[bpfa_pkg::FRAME_W-1:0];
      end
      idx -= lay_pages[r];
    end
    return '0;
  endfunction

  // First fit over the words that cover the page total.
  function automatic bpfa_pkg::status_t claim_first_free(
    output logic [bpfa_pkg::FRAME_W-1:0] frame);
    int unsigned limit = ((page_total + 31) >> 5) << 5;
    frame = '0;
    if (limit > PAGE_LIMIT) limit = PAGE_LIMIT;
    for (int unsigned i = 0; i < limit; i++) begin
      if (page_free[i]) begin
        page_free[i] = 1'b0;
        frame = frame_of_page(i);
        return bpfa_pkg::STATUS_OK;
      end
    end
    return bpfa_pkg::STATUS_OOM;
  endfunction

  // Address to page index; the lowest numbered matching region wins.
  function automatic bpfa_pkg::status_t release_page(logic [bpfa_pkg::ADDR_W-1:0] addr);
    int unsigned n = live_regions();
    int unsigned prefix = 0;
    int unsigned frame;
    int unsigned idx = 0;
    bit hit = 1'b0;
    if (addr[bpfa_pkg::OFFSET_W-1:0] != '0) return bpfa_pkg::STATUS_BAD;
    frame = addr >> bpfa_pkg::OFFSET_W;
    for (int r = 0; r < n; r++) begin
      if (!hit) begin
        if (frame >= lay_base[r] && frame - lay_base[r] < lay_pages[r]) begin
          idx = prefix + frame - lay_base[r];
          hit = 1'b1;
        end else begin
          prefix += lay_pages[r];
        end
      end
    end
    if (!hit || idx >= page_total) return bpfa_pkg::STATUS_BAD;
    if (page_free[idx]) return bpfa_pkg::STATUS_DOUBLE;
    page_free[idx] = 1'b1;
    return bpfa_pkg::STATUS_OK;
  endfunction

  function automatic page_resp_t predict_outcome(page_req_t r);
    page_resp_t o;
    logic [bpfa_pkg::FRAME_W-1:0] f;
    o.frame  = '0;
    o.status = bpfa_pkg::STATUS_OK;
    case (r.action)
      bpfa_pkg::ACT_INIT: rebuild_bitmap();
      bpfa_pkg::ACT_ALLOC: begin
        o.status = claim_first_free(f);
        if (o.status == bpfa_pkg::STATUS_OK) o.frame = f;
      end
      bpfa_pkg::ACT_FREE: o.status = release_page(r.addr);
      default: ;
    endcase
    return o;
  endfunction

  task automatic queue_item(bpfa_pkg::action_t a, logic [bpfa_pkg::ADDR_W-1:0] addr);
    page_req_t r;
    r.action = a;
    r.addr   = addr;
    request_q.push_back(r);
    reqs_issued++;
  endtask

  // Waits until every item has been taken and every result has come back.
  task automatic wait_idle();
    do @(posedge clk); while (reqs_taken != reqs_issued || outcome_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // One register write; the caller lowers cfg_valid after the last one.
  task automatic write_reg(bpfa_pkg::cfg_index_t idx, logic [bpfa_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bpfa_pkg::CFG_REGION0_BASE:  lay_base[0]  = val[bpfa_pkg::FRAME_W-1:0];
      bpfa_pkg::CFG_REGION0_PAGES: lay_pages[0] = val[bpfa_pkg::PAGES_W-1:0];
      bpfa_pkg::CFG_REGION1_BASE:  lay_base[1]  = val[bpfa_pkg::FRAME_W-1:0];
      bpfa_pkg::CFG_REGION1_PAGES: lay_pages[1] = val[bpfa_pkg::PAGES_W-1:0];
      bpfa_pkg::CFG_REGION2_BASE:  lay_base[2]  = val[bpfa_pkg::FRAME_W-1:0];
      bpfa_pkg::CFG_REGION2_PAGES: lay_pages[2] = val[bpfa_pkg::PAGES_W-1:0];
      bpfa_pkg::CFG_REGIONS_USED:  lay_used     = val[1:0];
      bpfa_pkg::CFG_RESERVED:      lay_reserved = val[bpfa_pkg::PAGES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_layout(int unsigned b0, int unsigned p0, int unsigned b1,
                                int unsigned p1, int unsigned b2, int unsigned p2,
                                int unsigned used, int unsigned rsv);
    write_reg(bpfa_pkg::CFG_REGION0_BASE, bpfa_pkg::CFG_DATA_W'(b0));
    write_reg(bpfa_pkg::CFG_REGION0_PAGES, bpfa_pkg::CFG_DATA_W'(p0));
    write_reg(bpfa_pkg::CFG_REGION1_BASE, bpfa_pkg::CFG_DATA_W'(b1));
    write_reg(bpfa_pkg::CFG_REGION1_PAGES, bpfa_pkg::CFG_DATA_W'(p1));
    write_reg(bpfa_pkg::CFG_REGION2_BASE, bpfa_pkg::CFG_DATA_W'(b2));
    write_reg(bpfa_pkg::CFG_REGION2_PAGES, bpfa_pkg::CFG_DATA_W'(p2));
    write_reg(bpfa_pkg::CFG_REGIONS_USED, bpfa_pkg::CFG_DATA_W'(used));
    write_reg(bpfa_pkg::CFG_RESERVED, bpfa_pkg::CFG_DATA_W'(rsv));
    cfg_valid <= 1'b0;
  endtask

  // Mostly aligned addresses near the configured regions, some broken ones.
  function automatic logic [bpfa_pkg::ADDR_W-1:0] pick_release_address();
    int unsigned r = $urandom_range(0, REGION_SLOTS - 1);
    int unsigned pick = $urandom_range(0, 99);
    int unsigned off;
    logic [31:0] fsum;
    off  = $urandom_range(0, lay_pages[r] + 1);
    fsum = lay_base[r] + off;
    if (pick < 70) return {fsum[bpfa_pkg::FRAME_W-1:0], 12'h000};
    if (pick < 80) return {fsum[bpfa_pkg::FRAME_W-1:0], 12'($urandom_range(1, 4095))};
    if (pick < 90) return $urandom() & 32'hFFFF_F000;
    return $urandom();
  endfunction

  // A random layout followed by a run of mixed items.
  task automatic random_phase(int n_items);
    int unsigned b [REGION_SLOTS];
    int unsigned p [REGION_SLOTS];
    int unsigned used, rsv, sum, kind, pick;
    kind = $urandom_range(0, 9);
    for (int r = 0; r < REGION_SLOTS; r++) begin
      b[r] = $urandom_range(0, 20'hFFFFF);
      if ($urandom_range(0, 3) == 0) b[r] = 20'hFFFFF - $urandom_range(0, 40);
      if (r > 0 && $urandom_range(0, 3) == 0) b[r] = (b[r-1] + $urandom_range(0, 30)) & 20'hFFFFF;
      if (kind == 0) p[r] = $urandom_range(0, 1) ? PAGE_LIMIT : $urandom_range(10000, PAGE_LIMIT);
      else if (kind == 1) p[r] = $urandom_range(0, 2);
      else p[r] = $urandom_range(0, 70);
    end
    used = $urandom_range(0, 4);
    if (used > 3) used = 3;
    sum = p[0] + p[1] + p[2];
    if (sum > PAGE_LIMIT) sum = PAGE_LIMIT;
    pick = $urandom_range(0, 9);
    if (pick < 2) rsv = 0;
    else if (kind == 0 && pick == 9) rsv = sum - $urandom_range(0, 64);
    else rsv = $urandom_range(0, (sum < 40) ? sum + 4 : 40);
    program_layout(b[0], p[0], b[1], p[1], b[2], p[2], used, rsv);
    // Now and then the old bitmap is kept under the new layout.
    if ($urandom_range(0, 9) != 0) queue_item(bpfa_pkg::ACT_INIT, $urandom());
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) queue_item(bpfa_pkg::ACT_ALLOC, $urandom());
      else if (pick < 86) queue_item(bpfa_pkg::ACT_FREE, pick_release_address());
      else if (pick < 93) queue_item(bpfa_pkg::ACT_INIT, $urandom());
      else queue_item(bpfa_pkg::ACT_NOP, $urandom());
    end
  endtask

  // Sender: bursts of items with random gaps; a stalled item is held.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_action       <= bpfa_pkg::ACT_NOP;
      in_free_address <= '0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      launch_valid = in_valid;
      if (in_valid && !in_stall) begin
        outcome_q.push_back(predict_outcome(cur_req));
        reqs_taken++;
        launch_valid = 1'b0;
      end
      if (!launch_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          launch_valid = 1'b1;
          in_action       <= cur_req.action;
          in_free_address <= cur_req.addr;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            case ($urandom_range(0, 4))
              0, 1: gap_left = 0;
              2, 3: gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(10, 40);
            endcase
          end
        end
      end
      in_valid <= launch_valid;
    end
  end

  // Receiver: stall pattern plus the check of each result transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          flag_error($sformatf("result frame %h status %0d with nothing outstanding",
                               out_page_frame, out_status));
        end else begin
          want_now = outcome_q.pop_front();
          if (out_page_frame !== want_now.frame)
            flag_error($sformatf("page_frame %h, expected %h", out_page_frame, want_now.frame));
          if (out_status !== want_now.status)
            flag_error($sformatf("status %0d, expected %s", out_status, want_now.status.name()));
        end
      end
      if (mode_span == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_span  = $urandom_range(20, 200);
      end
      mode_span--;
      if (stall_span > 0) begin
        stall_span--;
        next_stall = 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:   next_stall = 1'b0;
          STALL_SPARSE: next_stall = ($urandom_range(0, 3) == 0);
          default: begin
            next_stall = ($urandom_range(0, 15) == 0);
            if (next_stall) stall_span = $urandom_range(2, 12);
          end
        endcase
      end
      out_stall <= next_stall;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight after reset: no pages at all, no regions.
    queue_item(bpfa_pkg::ACT_ALLOC, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_FREE, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_NOP, 32'hFFFF_FFFF);
    wait_idle();

    // Region zero wraps past the top frame; regions one and two overlap.
    program_layout(20'hFFFFD, 40, 20'h00100, 8, 20'h00100, 5, 3, 2);
    queue_item(bpfa_pkg::ACT_INIT, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_ALLOC, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_ALLOC, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_FREE, 32'hFFFF_F000);
    queue_item(bpfa_pkg::ACT_FREE, 32'hFFFF_F000);
    queue_item(bpfa_pkg::ACT_FREE, 32'h0010_0FFF);
    queue_item(bpfa_pkg::ACT_FREE, 32'h0010_4000);
    queue_item(bpfa_pkg::ACT_FREE, 32'h0010_8000);
    queue_item(bpfa_pkg::ACT_FREE, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_FREE, 32'hFFFF_D000);
    wait_idle();

    // Three pages: run out of memory, then give one back.
    program_layout(20'h00010, 3, 0, 0, 0, 0, 1, 1);
    queue_item(bpfa_pkg::ACT_INIT, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_ALLOC, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_ALLOC, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_ALLOC, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_FREE, 32'h0001_1000);
    queue_item(bpfa_pkg::ACT_ALLOC, 32'h0000_0000);
    wait_idle();

    // More reserved pages than there are pages.
    program_layout(20'h00010, 3, 0, 0, 0, 0, 1, 5);
    queue_item(bpfa_pkg::ACT_INIT, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_ALLOC, 32'h0000_0000);
    wait_idle();

    // Page total saturates; only the very last page is free.
    program_layout(20'h00000, PAGE_LIMIT, 20'h80000, PAGE_LIMIT, 20'hF0000, PAGE_LIMIT,
                   3, PAGE_LIMIT - 1);
    queue_item(bpfa_pkg::ACT_INIT, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_ALLOC, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_ALLOC, 32'h0000_0000);
    queue_item(bpfa_pkg::ACT_FREE, 32'h8000_0000);
    wait_idle();

    // Random layouts, each drained before the next is programmed.
    for (int ph = 0; ph < 20; ph++) begin
      random_phase(28);
      wait_idle();
    end

    repeat (1100) @(posedge clk);
    if (outcome_q.size() != 0) flag_error("results still outstanding at the end");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
